@@ design/sspq_pkg.sv @@
// Shared types and codes for the stable sorted priority queue.
// Used by sspq_store and stable_sorted_priority_queue_unit; no dependencies.
package sspq_pkg;

	// Default number of queue slots
	localparam int DEPTH_DEF = 16;

	// Fixed field widths
	localparam int PRIO_W = 16;
	localparam int TAG_W  = 64;
	localparam int FILL_W = 5;

	// Packed stream widths, rounded up to whole bytes
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 88;

	// Request kinds
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	// One stored queue entry
	typedef struct packed {
		logic signed [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]         tag;
	} entry_t;

endpackage

@@ design/sspq_store.sv @@
// Entry memory of the priority queue: one write port, one read port with
// registered read data. Depends on sspq_pkg for the entry type.
module sspq_store
	import sspq_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEPTH_DEF,
	parameter int ADDR_W      = $clog2(QUEUE_DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  entry_t            wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output entry_t            rd_data
);

	entry_t mem_q [QUEUE_DEPTH];
	entry_t rd_data_q;

	// Write one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read one entry, data valid the next cycle
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ design/stable_sorted_priority_queue_unit.sv @@
// Top level of the stable sorted priority queue: sequencer, head pointer,
// comparator and result register. Depends on sspq_pkg and sspq_store.
//
//  Channel   | Direction | tuser           | tdata
//  s_axis    | in        | op              | priority_req, name_tag
//  m_axis    | out       | status          | out_priority, out_tag, fill_level
//
// A remove reads the head entry (ST_RM_RD, ST_RM_CAP); a flagged request goes straight
// to ST_RESULT; an insert reads and compares each stored entry in turn (ST_INS_RD, ST_INS_CMP):
// every entry greater than the new one moves up a slot, and the first one that is not ends it.
// The walk is paced by the registered read of the single-read-port entry memory
// and the one shared priority comparator walking from the rear.
// Entries sit in a ring; a remove only advances the head pointer.
// Reset clears the count, head pointer, sequencer and result register; the
// memory needs no clearing. A stalled result waits in the output register
// while the next request is taken.
module stable_sorted_priority_queue_unit
	import sspq_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [15:0] priority_req, [79:16] name_tag
	input  logic                  s_axis_tuser,  // [0] op
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [15:0] out_priority, [79:16] out_tag,
	                                             // [84:80] fill_level, [87:85] zero
	output logic [1:0]            m_axis_tuser   // [1:0] status
);

	localparam int ADDR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_INS_RD  = 7'b0000010,
		ST_INS_CMP = 7'b0000100,
		ST_PLACE   = 7'b0001000,
		ST_RM_RD   = 7'b0010000,
		ST_RM_CAP  = 7'b0100000,
		ST_RESULT  = 7'b1000000
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         steps_q;
	logic [ADDR_W-1:0]        head_q;
	logic [ADDR_W-1:0]        wr_ptr_q;
	logic signed [PRIO_W-1:0] key_q;
	logic [TAG_W-1:0]         tag_q;
	status_t                  res_status_q;
	entry_t                   res_entry_q;

	logic                     out_valid_q;
	status_t                  out_status_q;
	entry_t                   out_entry_q;
	logic [FILL_W-1:0]        out_fill_q;

	logic                     in_fire;
	op_t                      in_op;
	logic                     full;
	logic                     empty;
	logic [ADDR_W:0]          tail_sum;
	logic [ADDR_W-1:0]        tail_ptr;
	logic [ADDR_W-1:0]        prev_ptr;
	logic [ADDR_W-1:0]        next_head;
	logic                     mem_wr_en;
	logic [ADDR_W-1:0]        mem_rd_addr;
	entry_t                   mem_wr_data;
	entry_t                   mem_rd_data;
	logic                     shift_up;
	logic                     out_free;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign in_op    = op_t'(s_axis_tuser);
	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign out_free = !out_valid_q || m_axis_tready;

	// Ring pointer arithmetic: tail, one slot back, one slot forward
	assign tail_sum  = {1'b0, head_q} + (ADDR_W+1)'(count_q);
	assign tail_ptr  = (tail_sum >= (ADDR_W+1)'(QUEUE_DEPTH)) ?
		ADDR_W'(tail_sum - (ADDR_W+1)'(QUEUE_DEPTH)) : ADDR_W'(tail_sum);
	assign prev_ptr  = (wr_ptr_q == '0) ? ADDR_W'(QUEUE_DEPTH - 1) : wr_ptr_q - 1'b1;
	assign next_head = (head_q == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

	// Shared comparator: stored entry moves up when its priority is greater
	assign shift_up = ($signed(mem_rd_data.prio) > key_q);

	// Memory port control
	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_data = mem_rd_data;
		mem_rd_addr = prev_ptr;
		case (state_q)
			ST_INS_CMP: begin
				mem_wr_en = shift_up;
			end
			ST_PLACE: begin
				mem_wr_en        = 1'b1;
				mem_wr_data.prio = key_q;
				mem_wr_data.tag  = tag_q;
			end
			ST_RM_RD: begin
				mem_rd_addr = head_q;
			end
			default: begin
				mem_wr_en = 1'b0;
			end
		endcase
	end

	sspq_store #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.ADDR_W     (ADDR_W)
	) u_store (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(wr_ptr_q),
		.wr_data(mem_wr_data),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	assign s_axis_tready = (state_q == ST_IDLE);

	// Capture the request payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			key_q <= s_axis_tdata[PRIO_W-1:0];
			tag_q <= s_axis_tdata[PRIO_W+TAG_W-1:PRIO_W];
		end
	end

	// Sequencer, count and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			steps_q      <= '0;
			head_q       <= '0;
			wr_ptr_q     <= '0;
			res_status_q <= STAT_DONE;
			res_entry_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						res_entry_q <= '0;
						if (in_op == OP_INSERT) begin
							if (full) begin
								res_status_q <= STAT_FULL;
								state_q      <= ST_RESULT;
							end else begin
								res_status_q <= STAT_DONE;
								wr_ptr_q     <= tail_ptr;
								steps_q      <= count_q;
								state_q      <= empty ? ST_PLACE : ST_INS_RD;
							end
						end else begin
							if (empty) begin
								res_status_q <= STAT_EMPTY;
								state_q      <= ST_RESULT;
							end else begin
								res_status_q <= STAT_DONE;
								state_q      <= ST_RM_RD;
							end
						end
					end
				end
				ST_INS_RD: begin
					state_q <= ST_INS_CMP;
				end
				ST_INS_CMP: begin
					// Move the greater entry up one slot, or stop the walk
					if (shift_up) begin
						wr_ptr_q <= prev_ptr;
						steps_q  <= steps_q - 1'b1;
						state_q  <= (steps_q == CNT_W'(1)) ? ST_PLACE : ST_INS_RD;
					end else begin
						state_q <= ST_PLACE;
					end
				end
				ST_PLACE: begin
					count_q <= count_q + 1'b1;
					state_q <= ST_RESULT;
				end
				ST_RM_RD: begin
					state_q <= ST_RM_CAP;
				end
				ST_RM_CAP: begin
					res_entry_q <= mem_rd_data;
					head_q      <= next_head;
					count_q     <= count_q - 1'b1;
					state_q     <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the result until the downstream side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESULT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT && out_free) begin
			out_status_q <= res_status_q;
			out_entry_q  <= res_entry_q;
			out_fill_q   <= FILL_W'(count_q);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {(OUT_DATA_W-PRIO_W-TAG_W-FILL_W)'(0), out_fill_q,
		out_entry_q.tag, out_entry_q.prio};

`ifndef SYNTHESIS
	// Stored entries never exceed the ring size
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count above queue depth");

	// A flagged result carries no entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_status_q != STAT_DONE) |->
		(out_entry_q.prio == '0 && out_entry_q.tag == '0))
		else $error("flagged result carries entry data");

	// A remove on empty reports an empty queue
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_status_q == STAT_EMPTY) |-> (out_fill_q == '0))
		else $error("empty remove reports nonzero fill level");

	// The walk never runs past the stored entries
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS_CMP) |-> (steps_q != '0 && steps_q <= count_q))
		else $error("insert walk out of range");
`endif

endmodule

@@ tb/stable_sorted_priority_queue_unit_tb.sv @@
// Self-checking testbench for stable_sorted_priority_queue_unit: directed and random
// insert/remove requests, checked against a sorted-list predictor kept in the bench.
// Depends on sspq_pkg and the unit itself.
module stable_sorted_priority_queue_unit_tb;
	import sspq_pkg::*;

	localparam int DEPTH         = DEPTH_DEF;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 2 * DEPTH + 8;

	// One expected result
	typedef struct {
		status_t                  status;
		logic signed [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]         tag;
		logic [FILL_W-1:0]        fill;
	} outcome_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;   // [15:0] priority_req, [79:16] name_tag
	logic                  s_axis_tuser;   // [0] op
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;   // [15:0] out_priority, [79:16] out_tag,
	                                       // [84:80] fill_level
	logic [1:0]            m_axis_tuser;   // [1:0] status

	entry_t   sorted_entries[$];   // bench copy of the queue, front first
	outcome_t awaited_results[$];  // results owed by the unit, oldest first
	int       fail_count  = 0;
	int       cycle_count = 0;
	bit       calm        = 1'b0;  // no idling on either side while set

	stable_sorted_priority_queue_unit #(
		.QUEUE_DEPTH(DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Apply one request to the bench queue and return the result it owes
	function automatic outcome_t apply_request(op_t op, logic signed [PRIO_W-1:0] prio,
			logic [TAG_W-1:0] tag);
		outcome_t res;
		entry_t   ent;
		int       pos;
		res.status = STAT_DONE;
		res.prio   = '0;
		res.tag    = '0;
		if (op == OP_INSERT) begin
			if (sorted_entries.size() >= DEPTH) begin
				res.status = STAT_FULL;
			end else begin
				// place after every entry with priority <= the new one
				pos = 0;
				while (pos < sorted_entries.size() &&
						$signed(sorted_entries[pos].prio) <= $signed(prio))
					pos++;
				ent.prio = prio;
				ent.tag  = tag;
				sorted_entries.insert(pos, ent);
			end
		end else if (sorted_entries.size() == 0) begin
			res.status = STAT_EMPTY;
		end else begin
			ent      = sorted_entries.pop_front();
			res.prio = ent.prio;
			res.tag  = ent.tag;
		end
		res.fill = FILL_W'(sorted_entries.size());
		return res;
	endfunction

	// Random idle gap before the next request, for about one request in four
	function automatic int pick_gap();
		int gap = 0;
		if (calm)
			return 0;
		while (gap < 12 && $urandom_range(99) < 26)
			gap++;
		return gap;
	endfunction

	// Mix of tight ties, extremes and full-range priorities
	function automatic logic signed [PRIO_W-1:0] rand_priority();
		case ($urandom_range(3))
			0: return $signed(PRIO_W'($urandom_range(6))) - 16'sd3;
			1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			default: return PRIO_W'($urandom);
		endcase
	endfunction

	// Drive one request, hold it until accepted, then record its result
	task automatic send_request(op_t op, logic signed [PRIO_W-1:0] prio,
			logic [TAG_W-1:0] tag);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {tag, prio};
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		awaited_results.push_back(apply_request(op, prio, tag));
	endtask

	// Stop sending and hold until every owed result has come back
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_remove_empty();
		send_request(OP_REMOVE, 16'sh8000, '1);
		send_request(OP_REMOVE, 16'sh7fff, '0);
	endtask

	// Fill every slot with mostly descending priorities, ties and extremes, then overflow
	task automatic test_fill_to_full();
		logic signed [PRIO_W-1:0] prios [DEPTH] = '{
			16'sh7fff, 16'sh7fff, 16'sd1000, 16'sd1, 16'sd0, 16'sd0, -16'sd1, -16'sd1,
			-16'sd1, -16'sd7, -16'sd300, -16'sd32767, 16'sh8000, 16'sh8000, 16'sd5, 16'sd0};
		logic [TAG_W-1:0] tag;
		for (int k = 0; k < DEPTH; k++) begin
			tag = (k == 0) ? '0 : (k == 1) ? '1 : {$urandom, $urandom};
			send_request(OP_INSERT, prios[k], tag);
		end
		send_request(OP_INSERT, 16'sh8000, '1);
	endtask

	task automatic test_take_front(int count);
		repeat (count)
			send_request(OP_REMOVE, rand_priority(), {$urandom, $urandom});
	endtask

	// Random traffic in phases that lean toward filling, draining or balance
	task automatic test_random_mix(int count);
		int insert_pct;
		op_t op;
		insert_pct = 50;
		for (int k = 0; k < count; k++) begin
			if (k % 48 == 0)
				case ($urandom_range(2))
					0: insert_pct = 85;
					1: insert_pct = 15;
					default: insert_pct = 50;
				endcase
			op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
			send_request(op, rand_priority(), {$urandom, $urandom});
		end
	endtask

	// Random traffic with both sides always ready
	task automatic test_back_to_back(int count);
		calm = 1'b1;
		test_random_mix(count);
		calm = 1'b0;
	endtask

	// Receiver side stalls at random
	always @(negedge clk)
		m_axis_tready <= calm || ($urandom_range(99) >= 26);

	// Compare each accepted result with the oldest owed one
	always @(posedge clk) begin : check_results
		outcome_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result, status %0d tdata %h",
					$time, m_axis_tuser, m_axis_tdata);
				fail_count++;
			end else begin
				want = awaited_results.pop_front();
				if (m_axis_tuser !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, m_axis_tuser);
					fail_count++;
				end
				if ($signed(m_axis_tdata[15:0]) !== want.prio) begin
					$display("%0t: out_priority expected %0d actual %0d",
						$time, want.prio, $signed(m_axis_tdata[15:0]));
					fail_count++;
				end
				if (m_axis_tdata[79:16] !== want.tag) begin
					$display("%0t: out_tag expected %h actual %h",
						$time, want.tag, m_axis_tdata[79:16]);
					fail_count++;
				end
				if (m_axis_tdata[84:80] !== want.fill) begin
					$display("%0t: fill_level expected %0d actual %0d",
						$time, want.fill, m_axis_tdata[84:80]);
					fail_count++;
				end
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_INSERT;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_remove_empty();
		test_fill_to_full();
		test_take_front(5);
		wait_drained();
		test_random_mix(700);
		test_back_to_back(240);
		test_random_mix(500);
		wait_drained();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ stable_sorted_priority_queue_unit.f @@
design/sspq_pkg.sv
design/sspq_store.sv
design/stable_sorted_priority_queue_unit.sv
tb/stable_sorted_priority_queue_unit_tb.sv
